### design/http_message_framer_top_defines.svh
// assertion macros shared by the framer checks
`ifndef HTTP_MESSAGE_FRAMER_TOP_DEFINES_SVH
`define HTTP_MESSAGE_FRAMER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define HMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define HMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/hmf_pkg.sv
// types and codes shared by the http message framer
`timescale 1ns / 1ps
`default_nettype none

package hmf_pkg;

  // error codes carried on the end-of-headers beat
  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_NO_DIGITS  = 2'd1,
    ERR_BAD_LENGTH = 2'd2
  } hmf_error_e;

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        in_body;
    logic        last;
    hmf_error_e  error;
    logic [30:0] body_length;
  } out_item_t;

endpackage

`default_nettype wire

### design/hmf_pipe_reg.sv
// valid/ready register slice, one beat of storage
`timescale 1ns / 1ps
`default_nettype none

module hmf_pipe_reg #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [WIDTH-1:0]      out_data_o
);

  logic             valid_q, valid_d;
  logic [WIDTH-1:0] data_q;

  // take a new beat when empty or when the held one leaves
  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

### design/hmf_parser.sv
// header matchers, content length parser and body counter
`timescale 1ns / 1ps
`default_nettype none

module hmf_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire hmf_pkg::in_item_t item_i,
  output hmf_pkg::out_item_t     result_o
);

  localparam int         LB          = LENGTH_BITS;
  localparam logic [4:0] WindowBytes = 5'd30;
  localparam logic [3:0] KeywordLen  = 4'd15;
  localparam logic [2:0] EndLen      = 3'd4;

  typedef enum logic [2:0] {
    NP_IDLE,
    NP_SKIP,
    NP_SIGN,
    NP_DIGITS,
    NP_ACCEPT,
    NP_NO_DIGITS,
    NP_BAD
  } num_phase_e;

  typedef enum logic [1:0] {
    MP_HEADER,
    MP_BODY,
    MP_DONE
  } msg_phase_e;

  // keyword characters, "Content-Length:"
  function automatic logic [7:0] kw_char(input logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = "C";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "L";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      4'd14:   ch = ":";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // close the number: accept, flag bad length or flag missing digits
  function automatic num_phase_e finish_num(input num_phase_e np, input logic neg,
                                            input logic [LB-1:0] lv);
    num_phase_e r;
    case (np)
      NP_DIGITS:        r = ((neg && (lv != '0)) || lv[LB-1]) ? NP_BAD : NP_ACCEPT;
      NP_SKIP, NP_SIGN: r = NP_NO_DIGITS;
      default:          r = np;
    endcase
    return r;
  endfunction

  num_phase_e    np_q, np_d;
  msg_phase_e    mp_q, mp_d;
  logic [2:0]    ep_q, ep_d;
  logic [3:0]    kp_q, kp_d;
  logic [4:0]    wc_q, wc_d;
  logic [LB-1:0] lv_q, lv_d;
  logic          neg_q, neg_d;
  logic [LB-1:0] bc_q, bc_d;

  logic [7:0]    c;
  logic          is_digit;
  logic          is_space;
  logic [3:0]    digit;
  logic [LB+3:0] prod;
  logic [LB+30:0] len_ext;
  logic          in_body;
  logic          last;
  hmf_pkg::hmf_error_e err;

  assign c        = item_i.data_byte;
  assign is_digit = (c >= "0") && (c <= "9");
  assign is_space = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  assign digit    = c[3:0];
  // times ten plus digit, as two shifts and adds
  assign prod     = ({4'b0, lv_q} << 3) + ({4'b0, lv_q} << 1) + {{LB{1'b0}}, digit};

  // next state and result for one byte
  always_comb begin
    np_d    = np_q;
    mp_d    = mp_q;
    ep_d    = ep_q;
    kp_d    = kp_q;
    wc_d    = wc_q;
    lv_d    = lv_q;
    neg_d   = neg_q;
    bc_d    = bc_q;
    in_body = 1'b0;
    last    = 1'b0;
    err     = hmf_pkg::ERR_NONE;

    // start of message clears everything
    if (item_i.first) begin
      np_d  = NP_IDLE;
      mp_d  = MP_HEADER;
      ep_d  = '0;
      kp_d  = '0;
      wc_d  = '0;
      lv_d  = '0;
      neg_d = 1'b0;
      bc_d  = '0;
    end

    case (mp_d)
      MP_HEADER: begin
        // number parse inside the window
        if ((np_d == NP_SKIP) || (np_d == NP_SIGN) || (np_d == NP_DIGITS)) begin
          if (wc_d >= WindowBytes) begin
            np_d = finish_num(np_d, neg_d, lv_d);
          end else begin
            case (np_d)
              NP_SKIP: begin
                if (is_digit) begin
                  np_d = NP_DIGITS;
                  lv_d = {{(LB-4){1'b0}}, digit};
                end else if ((c == "+") || (c == "-")) begin
                  neg_d = (c == "-");
                  np_d  = NP_SIGN;
                end else if (!is_space) begin
                  np_d = NP_NO_DIGITS;
                end
              end
              NP_SIGN: begin
                if (is_digit) begin
                  np_d = NP_DIGITS;
                  lv_d = {{(LB-4){1'b0}}, digit};
                end else begin
                  np_d = NP_NO_DIGITS;
                end
              end
              default: begin
                if (is_digit) begin
                  // saturate just above the largest length
                  if (prod[LB+3:LB-1] != '0) begin
                    lv_d = {1'b1, {(LB-1){1'b0}}};
                  end else begin
                    lv_d = prod[LB-1:0];
                  end
                end else begin
                  np_d = finish_num(np_d, neg_d, lv_d);
                end
              end
            endcase
            wc_d = wc_d + 5'd1;
            if (wc_d >= WindowBytes) begin
              np_d = finish_num(np_d, neg_d, lv_d);
            end
          end
        end

        // keyword matcher, runs until the keyword is found
        if (np_d == NP_IDLE) begin
          if ((kp_d < KeywordLen) && (c == kw_char(kp_d))) begin
            kp_d = kp_d + 4'd1;
          end else begin
            kp_d = (c == kw_char(4'd0)) ? 4'd1 : 4'd0;
          end
          if (kp_d >= KeywordLen) begin
            np_d  = NP_SKIP;
            wc_d  = '0;
            lv_d  = '0;
            neg_d = 1'b0;
          end
        end

        // end of headers matcher, cr lf cr lf with fallback
        if ((ep_d < EndLen) && (c == (ep_d[0] ? 8'd10 : 8'd13))) begin
          ep_d = ep_d + 3'd1;
        end else begin
          ep_d = (c == 8'd13) ? 3'd1 : 3'd0;
        end
        if (ep_d >= EndLen) begin
          np_d = finish_num(np_d, neg_d, lv_d);
          if (np_d == NP_NO_DIGITS) begin
            err  = hmf_pkg::ERR_NO_DIGITS;
            last = 1'b1;
            mp_d = MP_DONE;
          end else if (np_d == NP_BAD) begin
            err  = hmf_pkg::ERR_BAD_LENGTH;
            last = 1'b1;
            mp_d = MP_DONE;
          end else if ((np_d == NP_ACCEPT) && (lv_d != '0)) begin
            mp_d = MP_BODY;
            bc_d = '0;
          end else begin
            last = 1'b1;
            mp_d = MP_DONE;
          end
        end
      end
      MP_BODY: begin
        in_body = 1'b1;
        bc_d    = bc_d + 1'b1;
        if (bc_d >= lv_d) begin
          last = 1'b1;
          mp_d = MP_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // length as shown on the result, zero until accepted
  assign len_ext = {31'b0, lv_d};

  always_comb begin
    result_o.out_byte    = c;
    result_o.in_body     = in_body;
    result_o.last        = last;
    result_o.error       = err;
    result_o.body_length = (np_d == NP_ACCEPT) ? len_ext[30:0] : 31'b0;
  end

  // parse state, advanced once per byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q  <= NP_IDLE;
      mp_q  <= MP_HEADER;
      ep_q  <= '0;
      kp_q  <= '0;
      wc_q  <= '0;
      lv_q  <= '0;
      neg_q <= 1'b0;
      bc_q  <= '0;
    end else if (step_i) begin
      np_q  <= np_d;
      mp_q  <= mp_d;
      ep_q  <= ep_d;
      kp_q  <= kp_d;
      wc_q  <= wc_d;
      lv_q  <= lv_d;
      neg_q <= neg_d;
      bc_q  <= bc_d;
    end
  end

endmodule

`default_nettype wire

### design/http_message_framer_top.sv
// HTTP message framer: one byte per cycle, input register, parser, result register
// Each accepted byte comes back as one result beat through the input register and
// then the result register, and a new byte is taken every cycle while results are
// taken: the parser updates all of its matchers, the times-ten length accumulator
// and the body counter combinationally between the input register and the result
// register. in_ready_o follows out_ready_i through the two register slices, so a
// stall on the result side holds at most two bytes inside the block.
`timescale 1ns / 1ps
`default_nettype none

module http_message_framer_top #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hmf_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hmf_pkg::out_item_t      out_data_o
);

  localparam int InWidth  = $bits(hmf_pkg::in_item_t);
  localparam int OutWidth = $bits(hmf_pkg::out_item_t);

  logic               s1_valid;
  logic               res_ready;
  hmf_pkg::in_item_t  s1_item;
  hmf_pkg::out_item_t result;
  logic [InWidth-1:0] s1_bits;
  logic [OutWidth-1:0] out_bits;

  // input register
  hmf_pipe_reg #(
    .WIDTH (InWidth)
  ) u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (s1_valid),
    .out_ready_i (res_ready),
    .out_data_o  (s1_bits)
  );

  assign s1_item = hmf_pkg::in_item_t'(s1_bits);

  // parser steps when the byte moves into the result register
  hmf_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_valid && res_ready),
    .item_i   (s1_item),
    .result_o (result)
  );

  // result register
  hmf_pipe_reg #(
    .WIDTH (OutWidth)
  ) u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (res_ready),
    .in_data_i   (result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_bits)
  );

  assign out_data_o = hmf_pkg::out_item_t'(out_bits);

endmodule

`default_nettype wire

### design/hmf_checker.sv
// port-level checks for the framer and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "http_message_framer_top_defines.svh"

module hmf_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire hmf_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire hmf_pkg::out_item_t out_data_o
);

  // a stalled result beat holds
  `HMF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result beat changed while stalled")

  // input back-pressure only comes from a stalled result
  `HMF_ASSERT_NOW(a_ready_cause, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without a stalled result")

  // an error ends the message on a header beat
  `HMF_ASSERT_NOW(a_err_last, out_valid_o && (out_data_o.error != hmf_pkg::ERR_NONE), out_data_o.last && !out_data_o.in_body, "error beat not a final header beat")

  // body beats only exist with a nonzero length
  `HMF_ASSERT_NOW(a_body_len, out_valid_o && out_data_o.in_body, out_data_o.body_length != 31'b0, "body beat with zero length")

endmodule

bind http_message_framer_top hmf_checker u_checker (.*);

`default_nettype wire
